FILE: rtl/fasta_base_filter_n_collapse_core_defines.svh
// Assertion macros for the FASTA base filter checker.
// Depends on nothing; included by the checker file.
`ifndef FASTA_BASE_FILTER_N_COLLAPSE_CORE_DEFINES_SVH
`define FASTA_BASE_FILTER_N_COLLAPSE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FBFNC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbfnc check failed");

// Next-cycle implication, disabled while reset is high.
`define FBFNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbfnc check failed");

`endif

FILE: rtl/fbfnc_pkg.sv
// Shared constants and types of the FASTA base filter.
// No dependencies; used by the interfaces, the decoder and the core.
package fbfnc_pkg;

   localparam int POS_BITS_DEFAULT = 32;
   localparam int CNT_BITS         = 32;
   localparam int OUT_POS_BITS     = 32;

   // Raw byte values of interest
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_HEADER  = 8'h3E;   // '>'
   localparam logic [7:0] CHAR_A       = 8'h61;   // 'a'
   localparam logic [7:0] CHAR_C       = 8'h63;   // 'c'
   localparam logic [7:0] CHAR_G       = 8'h67;   // 'g'
   localparam logic [7:0] CHAR_T       = 8'h74;   // 't'
   localparam logic [7:0] CHAR_N       = 8'h6E;   // 'n'
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;   // 'A'
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;   // 'Z'
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Base codes
   localparam logic [2:0] BASE_A = 3'd0;
   localparam logic [2:0] BASE_C = 3'd1;
   localparam logic [2:0] BASE_G = 3'd2;
   localparam logic [2:0] BASE_T = 3'd3;
   localparam logic [2:0] BASE_N = 3'd4;

   localparam int NUM_BASES = 5;

   // Classification of one raw byte
   typedef struct packed {
      logic       is_newline;
      logic       is_header_mark;
      logic       is_base;
      logic [2:0] base_code;
   } byte_class_type;

   // One result transaction
   typedef struct packed {
      logic [2:0]              base_code;
      logic                    new_symbol;
      logic                    run_ended;
      logic [OUT_POS_BITS-1:0] run_end_position;
      logic [CNT_BITS-1:0]     removed_total;
   } result_type;

endpackage

FILE: rtl/fbfnc_if.sv
// Valid/ready channel interfaces for the FASTA base filter.
// Depends on fbfnc_pkg for field widths.
interface fbfnc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface fbfnc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          base_code;
   logic                                new_symbol;
   logic                                run_ended;
   logic [fbfnc_pkg::OUT_POS_BITS-1:0]  run_end_position;
   logic [fbfnc_pkg::CNT_BITS-1:0]      removed_total;

   modport source (output valid, output base_code, output new_symbol, output run_ended,
                   output run_end_position, output removed_total, input ready);
   modport sink   (input valid, input base_code, input new_symbol, input run_ended,
                   input run_end_position, input removed_total, output ready);
endinterface

FILE: rtl/fasta_base_filter_n_collapse_core.sv
// FASTA base filter core: drops headers and non-acgtn bytes, collapses n runs.
// Depends on fbfnc_pkg, fbfnc_if and fbfnc_decode.
//
// One raw byte is taken per cycle, every cycle, as long as the two-entry
// result buffer (output register plus skid register) has room; each byte
// updates the line, run, position and mask state in the cycle it is taken,
// and its result, if any, is registered into the output or skid register.
// Header lines, newlines, dropped bytes and extra n of a run give no result.
// Position and removed-base counters saturate; run_end_position saturates at
// all ones when the position does not fit in 32 bits.
module fasta_base_filter_n_collapse_core #(
   parameter int POS_BITS = fbfnc_pkg::POS_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   fbfnc_req_if.sink         req_ch,
   fbfnc_rsp_if.source       rsp_ch
);

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_ONE,
      RUN_COLLAPSED
   } run_state_type;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [fbfnc_pkg::CNT_BITS-1:0] CNT_MAX = {fbfnc_pkg::CNT_BITS{1'b1}};

   // State registers
   logic                          at_line_start_ff, at_line_start_in;
   logic                          in_header_ff, in_header_in;
   run_state_type                 run_state_ff, run_state_in;
   logic [POS_BITS-1:0]           position_ff, position_in;
   logic                          pos_started_ff, pos_started_in;
   logic [fbfnc_pkg::CNT_BITS-1:0] removed_ff, removed_in;
   logic [fbfnc_pkg::NUM_BASES-1:0] seen_mask_ff, seen_mask_in;

   // Result buffer
   logic                          out_valid_ff, out_valid_in;
   fbfnc_pkg::result_type         out_data_ff, out_data_in;
   logic                          skid_valid_ff, skid_valid_in;
   fbfnc_pkg::result_type         skid_data_ff, skid_data_in;

   fbfnc_pkg::byte_class_type     byte_class;
   fbfnc_pkg::result_type         result;
   logic                          result_valid;
   logic                          req_take;
   logic                          rsp_take;
   logic                          seq_byte;
   logic [POS_BITS-1:0]           position_next;
   logic [63:0]                   position_wide;
   logic [fbfnc_pkg::NUM_BASES-1:0] base_bit;

   fbfnc_decode u_decode (
      .in_byte    (req_ch.in_byte),
      .byte_class (byte_class)
   );

   assign req_ch.ready = !skid_valid_ff;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_take     = out_valid_ff && rsp_ch.ready;

   // A byte is a sequence byte unless it is a newline, a header mark at line
   // start, or part of a header line
   assign seq_byte = !byte_class.is_newline && !in_header_ff &&
                     !(at_line_start_ff && byte_class.is_header_mark);

   // Advance position: first symbol is index zero, then count up and hold at max
   always_comb begin
      if (!pos_started_ff) begin
         position_next = '0;
      end else if (position_ff != POS_MAX) begin
         position_next = position_ff + POS_BITS'(1);
      end else begin
         position_next = position_ff;
      end
   end

   assign position_wide = 64'(position_next);
   assign base_bit      = fbfnc_pkg::NUM_BASES'(1) << byte_class.base_code;

   // Next state and result for the incoming byte
   always_comb begin
      at_line_start_in = at_line_start_ff;
      in_header_in     = in_header_ff;
      run_state_in     = run_state_ff;
      position_in      = position_ff;
      pos_started_in   = pos_started_ff;
      removed_in       = removed_ff;
      seen_mask_in     = seen_mask_ff;
      result_valid     = 1'b0;

      result.base_code        = byte_class.base_code;
      result.new_symbol       = !(|(seen_mask_ff & base_bit));
      result.run_ended        = 1'b0;
      result.run_end_position = '0;
      result.removed_total    = removed_ff;

      if (req_take) begin
         if (byte_class.is_newline) begin
            at_line_start_in = 1'b1;
            in_header_in     = 1'b0;
         end else begin
            at_line_start_in = 1'b0;
            if (at_line_start_ff && byte_class.is_header_mark) begin
               in_header_in = 1'b1;
            end
         end

         if (seq_byte && byte_class.is_base) begin
            position_in    = position_next;
            pos_started_in = 1'b1;
            if (byte_class.base_code == fbfnc_pkg::BASE_N && run_state_ff != RUN_NONE) begin
               // Drop the extra n and count it
               run_state_in = RUN_COLLAPSED;
               if (removed_ff != CNT_MAX) begin
                  removed_in = removed_ff + fbfnc_pkg::CNT_BITS'(1);
               end
            end else begin
               result_valid = 1'b1;
               seen_mask_in = seen_mask_ff | base_bit;
               if (byte_class.base_code == fbfnc_pkg::BASE_N) begin
                  run_state_in = RUN_ONE;
               end else begin
                  run_state_in = RUN_NONE;
                  if (run_state_ff == RUN_COLLAPSED) begin
                     result.run_ended        = 1'b1;
                     result.run_end_position = (|position_wide[63:32]) ? '1 :
                                               position_wide[31:0];
                  end
               end
            end
         end
      end
   end

   // Route results through the output register and the skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = result_valid;
            skid_data_in  = result;
         end else begin
            out_valid_in = result_valid;
            out_data_in  = result;
         end
      end else if (result_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         in_header_ff     <= 1'b0;
         run_state_ff     <= RUN_NONE;
         position_ff      <= POS_MAX;
         pos_started_ff   <= 1'b0;
         removed_ff       <= '0;
         seen_mask_ff     <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         at_line_start_ff <= at_line_start_in;
         in_header_ff     <= in_header_in;
         run_state_ff     <= run_state_in;
         position_ff      <= position_in;
         pos_started_ff   <= pos_started_in;
         removed_ff       <= removed_in;
         seen_mask_ff     <= seen_mask_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Drive the result channel
   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.base_code        = out_data_ff.base_code;
   assign rsp_ch.new_symbol       = out_data_ff.new_symbol;
   assign rsp_ch.run_ended        = out_data_ff.run_ended;
   assign rsp_ch.run_end_position = out_data_ff.run_end_position;
   assign rsp_ch.removed_total    = out_data_ff.removed_total;

endmodule

FILE: rtl/fbfnc_decode.sv
// Byte classifier: case folding and acgtn lookup for one raw byte.
// Depends on fbfnc_pkg.
module fbfnc_decode (
   input  logic [7:0]                in_byte,
   output fbfnc_pkg::byte_class_type byte_class
);

   logic [7:0] folded;

   // Fold upper-case ASCII letters to lower case
   always_comb begin
      if (in_byte >= fbfnc_pkg::CHAR_UPPER_A && in_byte <= fbfnc_pkg::CHAR_UPPER_Z) begin
         folded = in_byte + fbfnc_pkg::CASE_OFFSET;
      end else begin
         folded = in_byte;
      end
   end

   // Map the folded byte to a base code
   always_comb begin
      byte_class.is_newline     = (in_byte == fbfnc_pkg::CHAR_NEWLINE);
      byte_class.is_header_mark = (in_byte == fbfnc_pkg::CHAR_HEADER);
      byte_class.is_base        = 1'b1;
      byte_class.base_code      = fbfnc_pkg::BASE_A;
      unique case (folded)
         fbfnc_pkg::CHAR_A: byte_class.base_code = fbfnc_pkg::BASE_A;
         fbfnc_pkg::CHAR_C: byte_class.base_code = fbfnc_pkg::BASE_C;
         fbfnc_pkg::CHAR_G: byte_class.base_code = fbfnc_pkg::BASE_G;
         fbfnc_pkg::CHAR_T: byte_class.base_code = fbfnc_pkg::BASE_T;
         fbfnc_pkg::CHAR_N: byte_class.base_code = fbfnc_pkg::BASE_N;
         default:           byte_class.is_base   = 1'b0;
      endcase
   end

endmodule

FILE: rtl/fasta_base_filter_n_collapse_core_checker.sv
// Port-level checker for the FASTA base filter core, with its bind.
// Depends on fbfnc_pkg and the assertion macros header.
`include "fasta_base_filter_n_collapse_core_defines.svh"

module fasta_base_filter_n_collapse_core_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [2:0]                         rsp_base_code,
   input logic                               rsp_run_ended,
   input logic [fbfnc_pkg::OUT_POS_BITS-1:0] rsp_run_end_position
);

   // Only the five base codes leave the block
   `FBFNC_ASSERT_NOW(a_code_range, clock, reset, rsp_valid, rsp_base_code <= fbfnc_pkg::BASE_N)

   // A run can only be closed by a base other than n
   `FBFNC_ASSERT_NOW(a_end_not_n, clock, reset, rsp_valid && rsp_run_ended, rsp_base_code != fbfnc_pkg::BASE_N)

   // Position is reported only with a run end
   `FBFNC_ASSERT_NOW(a_pos_zero, clock, reset, rsp_valid && !rsp_run_ended, rsp_run_end_position == '0)

   // A stalled result transaction stays offered
   `FBFNC_ASSERT_NEXT(a_hold_valid, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind fasta_base_filter_n_collapse_core fasta_base_filter_n_collapse_core_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_base_code        (rsp_ch.base_code),
   .rsp_run_ended        (rsp_ch.run_ended),
   .rsp_run_end_position (rsp_ch.run_end_position)
);

FILE: bench/tb_fasta_base_filter_n_collapse_core.sv
// Self-checking bench for the FASTA base filter core with n-run collapse.
// Depends on fbfnc_pkg, fbfnc_if and the core RTL; drives bytes, checks results.
module tb_fasta_base_filter_n_collapse_core;

   localparam int POS_W        = fbfnc_pkg::POS_BITS_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ITEM_COUNT   = 1800;

   typedef enum logic [1:0] {
      RUN_NONE      = 2'd0,
      RUN_ONE       = 2'd1,
      RUN_COLLAPSED = 2'd2
   } run_state_type;

   // Scoreboard: tracks the block state and holds the results still owed
   class fasta_result_scoreboard;
      fbfnc_pkg::result_type                  expected_q[$];
      int unsigned                            error_count;
      bit                                     at_line_start;
      bit                                     in_header;
      bit                                     pos_started;
      run_state_type                          run_state;
      logic [POS_W-1:0]                       symbol_pos;
      logic [fbfnc_pkg::CNT_BITS-1:0]         removed_cnt;
      logic [fbfnc_pkg::NUM_BASES-1:0]        seen_mask;

      function new();
         error_count   = 0;
         at_line_start = 1'b1;
         in_header     = 1'b0;
         pos_started   = 1'b0;
         run_state     = RUN_NONE;
         symbol_pos    = '1;
         removed_cnt   = '0;
         seen_mask     = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Note one accepted byte and queue the result it causes, if any
      function void note_byte(logic [7:0] b);
         logic [7:0]                      folded;
         logic [2:0]                      code;
         bit                              is_base;
         fbfnc_pkg::result_type           res;
         logic [fbfnc_pkg::NUM_BASES-1:0] bit_sel;
         if (b == fbfnc_pkg::CHAR_NEWLINE) begin
            at_line_start = 1'b1;
            in_header     = 1'b0;
            return;
         end
         if (at_line_start) begin
            at_line_start = 1'b0;
            if (b == fbfnc_pkg::CHAR_HEADER) begin
               in_header = 1'b1;
               return;
            end
         end
         if (in_header) return;

         // Fold case, then classify
         folded  = (b >= fbfnc_pkg::CHAR_UPPER_A && b <= fbfnc_pkg::CHAR_UPPER_Z) ?
                   b + fbfnc_pkg::CASE_OFFSET : b;
         is_base = 1'b1;
         code    = fbfnc_pkg::BASE_A;
         case (folded)
            fbfnc_pkg::CHAR_A: code = fbfnc_pkg::BASE_A;
            fbfnc_pkg::CHAR_C: code = fbfnc_pkg::BASE_C;
            fbfnc_pkg::CHAR_G: code = fbfnc_pkg::BASE_G;
            fbfnc_pkg::CHAR_T: code = fbfnc_pkg::BASE_T;
            fbfnc_pkg::CHAR_N: code = fbfnc_pkg::BASE_N;
            default:           is_base = 1'b0;
         endcase
         if (!is_base) return;

         // Advance the saturating symbol position
         if (!pos_started) begin
            symbol_pos  = '0;
            pos_started = 1'b1;
         end else if (symbol_pos != '1) begin
            symbol_pos = symbol_pos + 1'b1;
         end

         res           = '0;
         res.base_code = code;
         if (code == fbfnc_pkg::BASE_N) begin
            // Drop an extra n of a run and count it
            if (run_state != RUN_NONE) begin
               run_state = RUN_COLLAPSED;
               if (removed_cnt != '1) removed_cnt = removed_cnt + 1'b1;
               return;
            end
            run_state = RUN_ONE;
         end else begin
            if (run_state == RUN_COLLAPSED) begin
               res.run_ended        = 1'b1;
               res.run_end_position =
                  (symbol_pos > {fbfnc_pkg::OUT_POS_BITS{1'b1}}) ?
                  '1 : symbol_pos[fbfnc_pkg::OUT_POS_BITS-1:0];
            end
            run_state = RUN_NONE;
         end

         bit_sel           = fbfnc_pkg::NUM_BASES'(1) << code;
         res.new_symbol    = ((seen_mask & bit_sel) == '0);
         res.removed_total = removed_cnt;
         seen_mask         = seen_mask | bit_sel;
         expected_q.insert(expected_q.size(), res);
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(fbfnc_pkg::result_type act);
         fbfnc_pkg::result_type exp;
         if (expected_q.size() == 0) begin
            $error("unexpected result: base_code %0d", act.base_code);
            error_count++;
            return;
         end
         exp = expected_q.pop_front();
         if (act.base_code !== exp.base_code) begin
            $error("base_code: expected %0d, actual %0d", exp.base_code, act.base_code);
            error_count++;
         end
         if (act.new_symbol !== exp.new_symbol) begin
            $error("new_symbol: expected %0d, actual %0d", exp.new_symbol, act.new_symbol);
            error_count++;
         end
         if (act.run_ended !== exp.run_ended) begin
            $error("run_ended: expected %0d, actual %0d", exp.run_ended, act.run_ended);
            error_count++;
         end
         if (act.run_end_position !== exp.run_end_position) begin
            $error("run_end_position: expected %0d, actual %0d",
                   exp.run_end_position, act.run_end_position);
            error_count++;
         end
         if (act.removed_total !== exp.removed_total) begin
            $error("removed_total: expected %0d, actual %0d",
                   exp.removed_total, act.removed_total);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   fbfnc_req_if req_bus ();
   fbfnc_rsp_if rsp_bus ();

   fasta_result_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int unsigned item_count = 0;
   int unsigned burst_left = 0;

   fasta_base_filter_n_collapse_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Clock generation
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Send one byte, wait for its transaction, then pace the next one
   task automatic push_byte(input logic [7:0] b);
      int unsigned gap;
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_byte(b);
      item_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // Random noise byte; most values are dropped, but some pass as bases
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 6))
         0:       return " ";
         1:       return 8'd13;
         2:       return 8'("0" + $urandom_range(0, 9));
         3:       return 8'("a" + $urandom_range(0, 25));
         4:       return 8'($urandom_range(128, 255));
         5:       return fbfnc_pkg::CHAR_HEADER;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Randomly raise a lower-case letter
   function automatic logic [7:0] mix_case(input logic [7:0] lc);
      return $urandom_range(0, 1) ? lc - fbfnc_pkg::CASE_OFFSET : lc;
   endfunction

   // Send one random line, mostly well-formed FASTA
   task automatic send_random_line();
      int unsigned kind;
      int unsigned len;
      int unsigned run_len;
      int unsigned pick;
      logic [7:0]  acgt [4];
      acgt = '{fbfnc_pkg::CHAR_A, fbfnc_pkg::CHAR_C, fbfnc_pkg::CHAR_G, fbfnc_pkg::CHAR_T};
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         // Header line, may contain base letters
         push_byte(fbfnc_pkg::CHAR_HEADER);
         len = $urandom_range(0, 20);
         repeat (len) push_byte($urandom_range(0, 1) ? acgt[$urandom_range(0, 3)] :
                                8'($urandom_range(32, 126)));
         push_byte(fbfnc_pkg::CHAR_NEWLINE);
      end else if (kind < 20) begin
         // Line of arbitrary bytes
         len = $urandom_range(1, 15);
         repeat (len) push_byte(8'($urandom_range(0, 255)));
         push_byte(fbfnc_pkg::CHAR_NEWLINE);
      end else if (kind < 23) begin
         push_byte(fbfnc_pkg::CHAR_NEWLINE);
      end else begin
         // Sequence line with n runs and some noise
         len = $urandom_range(1, 60);
         repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               push_byte(mix_case(acgt[$urandom_range(0, 3)]));
            end else if (pick < 78) begin
               run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) :
                                                       $urandom_range(1, 6);
               repeat (run_len) push_byte(mix_case(fbfnc_pkg::CHAR_N));
            end else if (pick < 90) begin
               push_byte(noise_byte());
            end else begin
               push_byte(mix_case(fbfnc_pkg::CHAR_N));
            end
         end
         if ($urandom_range(0, 19) != 0) push_byte(fbfnc_pkg::CHAR_NEWLINE);
      end
   endtask

   // Receiver: stall on a pattern that changes every so often
   initial begin
      int unsigned           rx_mode;
      int unsigned           rx_cycle;
      int unsigned           stall_left;
      logic                  rdy;
      fbfnc_pkg::result_type act;
      rx_mode    = 0;
      rx_cycle   = 0;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            act.base_code        = rsp_bus.base_code;
            act.new_symbol       = rsp_bus.new_symbol;
            act.run_ended        = rsp_bus.run_ended;
            act.run_end_position = rsp_bus.run_end_position;
            act.removed_total    = rsp_bus.removed_total;
            sb.check_result(act);
         end
         rx_cycle++;
         if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 9) < 7);
            2: rdy = (rx_cycle % 3 != 0);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rdy = 1'b0;
               end else if ($urandom_range(0, 9) == 0) begin
                  stall_left = $urandom_range(1, 8);
                  rdy = 1'b0;
               end else begin
                  rdy = 1'b1;
               end
            end
         endcase
         rsp_bus.ready <= rdy;
      end
   end

   // Sender: reset, directed bytes, random lines, then drain and report
   initial begin
      logic [7:0] directed [];
      directed = '{fbfnc_pkg::CHAR_HEADER, "a", fbfnc_pkg::CHAR_NEWLINE,
                   "A", "c", "G", "t", "N", "n", "N", "a",
                   "n", "n", fbfnc_pkg::CHAR_NEWLINE, fbfnc_pkg::CHAR_HEADER, "g",
                   fbfnc_pkg::CHAR_NEWLINE, "T", 8'h00, 8'hFF, fbfnc_pkg::CHAR_NEWLINE,
                   fbfnc_pkg::CHAR_NEWLINE, "Z", 8'd13, "n"};
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: header with a base letter, first occurrences, collapsed
      // run closed by a base, single n, run carried across a header line,
      // byte extremes, empty lines and dropped bytes
      foreach (directed[i]) push_byte(directed[i]);

      while (item_count < ITEM_COUNT) send_random_line();
      req_bus.valid <= 1'b0;

      // Drain outstanding results
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
